// ----- sv/hnms_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hnms_pkg
// Shared types and constants of the horizontal non-max suppression unit.
// ----------------------------------------------------------------------------
package hnms_pkg;

	// Pixel word (signed 16-bit gradient)
	localparam int PIX_W = 16;
	typedef logic signed [PIX_W-1:0] pixel_t;

	// Distance back along the row, wide enough for a window store of up to 63
	localparam int DIST_W = 6;
	typedef logic [DIST_W-1:0] dist_t;

	// Width used for column against row-width compares
	localparam int CMP_W = 17;
	typedef logic [CMP_W-1:0] colcmp_t;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_HALF_LENGTH = 1'd0;
	localparam cfg_idx_t REG_ROW_WIDTH   = 1'd1;

	localparam int CFG_DATA_W = 13;

	// Reset values of the registers
	localparam logic [3:0]            HALF_RESET  = 4'd1;
	localparam logic [CFG_DATA_W-1:0] WIDTH_RESET = 13'd640;

	// Window bounds broadcast along the cell chain, in distances from the newest pixel
	typedef struct packed {
		pixel_t cand;
		dist_t  d_lo;
		dist_t  d_hi;
	} win_t;

	// One result request from the sequencer
	typedef struct packed {
		logic  fire;
		dist_t dj;
		dist_t d_lo;
		dist_t d_hi;
		logic  row_end;
		logic  last;
	} job_t;

endpackage
`default_nettype wire

// ----- sv/hnms_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hnms_cell
// One window cell: holds a pixel, shifts it on, flags a larger pixel in window.
// ----------------------------------------------------------------------------
module hnms_cell #(
	parameter int INDEX = 0
) (
	input  wire logic            clk,
	input  wire logic            shift,
	input  wire hnms_pkg::pixel_t pix_in,
	input  wire hnms_pkg::win_t   win,
	output hnms_pkg::pixel_t      pix,
	output logic                  beats
);
	import hnms_pkg::*;

	localparam dist_t MY_DIST = DIST_W'(INDEX);

	pixel_t pix_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			pix_q <= pix_in;
		end
	end

	assign pix   = pix_q;
	// Only a strictly larger pixel inside the window suppresses the candidate
	assign beats = (MY_DIST >= win.d_lo) && (MY_DIST <= win.d_hi) && (pix_q > win.cand);

endmodule
`default_nettype wire

// ----- sv/hnms_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hnms_ctrl
// Config registers, column counter and result sequencer.
// ----------------------------------------------------------------------------
module hnms_ctrl #(
	parameter int MAX_HALF  = 15,
	parameter int MAX_WIDTH = 4096
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire hnms_pkg::cfg_idx_t    cfg_index,
	input  wire logic [12:0]           cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  out_free,
	output hnms_pkg::job_t             job
);
	import hnms_pkg::*;

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam colcmp_t WMAX = CMP_W'(MAX_WIDTH);
	localparam dist_t   LMAX = DIST_W'(MAX_HALF);

	logic [3:0]            half_q;
	logic [CFG_DATA_W-1:0] width_q;
	logic [CW-1:0]         col_q;
	logic [CW-1:0]         c_q;
	dist_t                 l_q;
	dist_t                 dj_q;
	logic                  end_q;
	logic                  pend_q;

	dist_t   l_now;
	colcmp_t w_now;
	colcmp_t col_ext;
	logic    end_now;
	logic    accept;
	logic    last_now;
	logic    fire;
	dist_t   sum;
	colcmp_t c_ext;
	logic    case_a;
	logic    case_b;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q  <= HALF_RESET;
			width_q <= WIDTH_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_HALF_LENGTH: half_q  <= cfg_data[3:0];
				REG_ROW_WIDTH:   width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the settings into the supported range
	always_comb begin
		l_now = (DIST_W'(half_q) > LMAX) ? LMAX : DIST_W'(half_q);
		w_now = CMP_W'(width_q);
		if (w_now == '0) begin
			w_now = CMP_W'(1);
		end else if (w_now > WMAX) begin
			w_now = WMAX;
		end
		col_ext = CMP_W'(col_q);
		end_now = (col_ext + CMP_W'(1)) >= w_now;
	end

	assign last_now = !end_q || (dj_q == '0);
	assign fire     = pend_q && out_free;
	assign in_ready = !pend_q || (fire && last_now);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			pend_q <= 1'b0;
			end_q  <= 1'b0;
			c_q    <= '0;
			l_q    <= '0;
			dj_q   <= '0;
		end else if (accept) begin
			c_q   <= col_q;
			l_q   <= l_now;
			end_q <= end_now;
			if (end_now) begin
				// Row end: flush columns back to min(L, c), oldest first
				dj_q   <= (col_ext < CMP_W'(l_now)) ? DIST_W'(col_q) : l_now;
				pend_q <= 1'b1;
				col_q  <= '0;
			end else begin
				dj_q   <= l_now;
				pend_q <= col_ext >= CMP_W'(l_now);
				col_q  <= CW'(col_ext + CMP_W'(1));
			end
		end else if (fire) begin
			if (last_now) begin
				pend_q <= 1'b0;
			end else begin
				dj_q <= dj_q - DIST_W'(1);
			end
		end
	end

	// Window of the column being judged, as distances back from the newest pixel
	always_comb begin
		sum    = dj_q + l_q;
		c_ext  = CMP_W'(c_q);
		case_a = end_q && (dj_q < l_q);
		case_b = c_ext < CMP_W'(sum);
		job.fire    = fire;
		job.dj      = dj_q;
		job.row_end = end_q && (dj_q == '0);
		job.last    = last_now;
		if (case_a) begin
			job.d_lo = dj_q;
			job.d_hi = case_b ? DIST_W'(c_q) : sum;
		end else begin
			job.d_lo = (dj_q > l_q) ? (dj_q - l_q) : '0;
			job.d_hi = case_b ? dj_q : sum;
		end
	end

endmodule
`default_nettype wire

// ----- sv/horizontal_non_max_suppression_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// horizontal_non_max_suppression_unit
// Horizontal non-max suppression of a raster gradient stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries gradient pixels in raster order; m_* returns suppressed pixels,
//   with m_tlast on the last column of a row and m_tuser on the final result
//   caused by one input request. cfg_* writes half_length (index 0) and
//   row_width (index 1); write only while the unit is idle.
// Path: a result is registered in the sequencer on the request that completes
//   its window (column j+L), then in the output register once that is free.
// Throughput: one pixel per clock inside a row while the output is free; the
//   pixel that ends a row flushes min(L, column)+1 results, one per cycle
//   while the output is free, with s_tready low until the flush is out.
// Reset: clears the column counter and sequencer and loads half_length = 1,
//   row_width = 640. The window chain is not cleared; it is only read for
//   pixels of the current row.
// Stall: while m_tready is low and the output register is full, it holds and
//   the sequencer stops; s_tready drops once a pending result cannot advance.
// ----------------------------------------------------------------------------
module horizontal_non_max_suppression_unit #(
	parameter int MAX_HALF  = 15,
	parameter int MAX_WIDTH = 4096
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Configuration write channel
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire hnms_pkg::cfg_idx_t    cfg_index,
	input  wire logic [12:0]           cfg_data,
	// Pixel input
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic signed [15:0]    s_tdata,   // [15:0] pixel_in
	// Result output
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic signed [15:0]         m_tdata,   // [15:0] pixel_out
	output logic                       m_tlast,   // row_end
	output logic                       m_tuser    // [0] last
);
	import hnms_pkg::*;

	// Window chain depth: the full window 2L+1 at the largest L
	localparam int DEPTH = 2 * MAX_HALF + 1;

	job_t   job;
	win_t   win;
	logic   out_free;
	logic   shift;
	pixel_t cand;
	logic   keep;

	pixel_t             pix   [DEPTH];
	logic [DEPTH-1:0]   beats;

	logic   out_valid_q;
	pixel_t out_pix_q;
	logic   out_row_end_q;
	logic   out_last_q;

	// Output register may take a new result when empty or being drained
	assign out_free = !out_valid_q || m_tready;

	hnms_ctrl #(
		.MAX_HALF  (MAX_HALF),
		.MAX_WIDTH (MAX_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_free  (out_free),
		.job       (job)
	);

	// Advance the chain by one column on every accepted request
	assign shift = s_tvalid && s_tready;

	// Pick the candidate pixel dj columns back
	always_comb begin
		cand = '0;
		for (int k = 0; k < DEPTH; k++) begin
			if (job.dj == DIST_W'(k)) begin
				cand = pix[k];
			end
		end
	end

	assign win.cand = cand;
	assign win.d_lo = job.d_lo;
	assign win.d_hi = job.d_hi;

	// Row of cells, newest pixel in cell 0
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_head
			hnms_cell #(.INDEX(g)) u_cell (
				.clk    (clk),
				.shift  (shift),
				.pix_in (s_tdata),
				.win    (win),
				.pix    (pix[g]),
				.beats  (beats[g])
			);
		end else begin : g_body
			hnms_cell #(.INDEX(g)) u_cell (
				.clk    (clk),
				.shift  (shift),
				.pix_in (pix[g-1]),
				.win    (win),
				.pix    (pix[g]),
				.beats  (beats[g])
			);
		end
	end

	// Keep the candidate when nothing in its window is larger; ties pass
	assign keep = ~|beats;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (job.fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load payload on each issued result; hold it while stalled
	always_ff @(posedge clk) begin
		if (job.fire) begin
			out_pix_q     <= keep ? cand : '0;
			out_row_end_q <= job.row_end;
			out_last_q    <= job.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_pix_q;
	assign m_tlast  = out_row_end_q;
	assign m_tuser  = out_last_q;

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the horizontal non-max suppression unit.
// ----------------------------------------------------------------------------
// Streams gradient pixels through the unit under a series of window and row
// settings and checks every result against a predictor of the suppression
// rule. The predictor keeps its own row history and column counter. Both
// stream sides idle at random in several phases. One phase holds the result
// side off for a long stretch so that the unit backs up into its input.
// ----------------------------------------------------------------------------
module tb;
	import hnms_pkg::*;

	localparam int          HISTORY     = 31;       // 2*MAX_HALF+1 pixels back
	localparam int          HOLD_CYCLES = 300;      // long result-side hold-off
	localparam int          DRAIN_WAIT  = 8;        // covers the sequencer and output registers
	localparam int unsigned CYCLE_LIMIT = 1000000;

	typedef struct {
		pixel_t pix;
		logic   row_end;
		logic   last;
	} nms_result_t;

	// Predicts the suppressed stream and checks the unit's results in order.
	class nms_scoreboard;
		pixel_t        row_hist[HISTORY];   // entry k: pixel k columns back
		int unsigned   column;
		logic [3:0]    half;
		logic [12:0]   width;
		nms_result_t   expected_pixels[$];
		int unsigned   mismatches;

		function new();
			foreach (row_hist[k])
				row_hist[k] = '0;
			column     = 0;
			half       = HALF_RESET;
			width      = WIDTH_RESET;
			mismatches = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [12:0] word);
			case (idx)
				REG_HALF_LENGTH: half  = word[3:0];
				REG_ROW_WIDTH:   width = word;
				default: ;
			endcase
		endfunction

		// Column j of a row of length r, with column c the newest pixel.
		function pixel_t suppress_column(int unsigned c, int unsigned r,
				int unsigned l, int unsigned j);
			int unsigned lo;
			int unsigned hi;
			pixel_t      v;
			pixel_t      peak;
			v = row_hist[c - j];
			// Near the row end look only left; this wins over the row start.
			if (j + l >= r) begin
				lo = (j >= l) ? j - l : 0;
				hi = j;
			end else if (j < l) begin
				lo = j;
				hi = j + l;
			end else begin
				lo = j - l;
				hi = j + l;
			end
			if (hi > c)
				hi = c;
			peak = v;
			for (int unsigned x = lo; x <= hi; x++)
				if (row_hist[c - x] > peak)
					peak = row_hist[c - x];
			return (v == peak) ? v : pixel_t'(0);
		endfunction

		function void push_result(pixel_t pix, logic row_end);
			nms_result_t r;
			r.pix     = pix;
			r.row_end = row_end;
			r.last    = 1'b0;
			expected_pixels.push_back(r);
		endfunction

		// Note an accepted pixel request and queue the results it completes.
		function void note_pixel(pixel_t v);
			int unsigned c;
			int unsigned w;
			int unsigned l;
			int unsigned n;
			c = column;
			w = width;
			l = half;
			n = 0;
			if (w < 1)
				w = 1;
			if (w > 4096)
				w = 4096;
			for (int k = HISTORY - 1; k > 0; k--)
				row_hist[k] = row_hist[k - 1];
			row_hist[0] = v;
			if (c + 1 >= w) begin
				// Row ends here (also when the width was lowered mid-row): flush.
				for (int unsigned j = (c >= l) ? c - l : 0; j <= c; j++) begin
					push_result(suppress_column(c, c + 1, l, j), j == c);
					n++;
				end
				column = 0;
			end else begin
				if (c >= l) begin
					push_result(suppress_column(c, w, l, c - l), 1'b0);
					n = 1;
				end
				column = c + 1;
			end
			if (n > 0)
				expected_pixels[$].last = 1'b1;
		endfunction

		function void check_result(pixel_t pix, logic row_end, logic last);
			nms_result_t e;
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: pixel %0d row_end %0b last %0b",
						pix, row_end, last);
				return;
			end
			e = expected_pixels.pop_front();
			if (pix !== e.pix || row_end !== e.row_end || last !== e.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
						e.pix, e.row_end, e.last, pix, row_end, last);
			end
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	cfg_idx_t    cfg_index = REG_HALF_LENGTH;
	logic [12:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	pixel_t      s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	pixel_t      m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	nms_scoreboard nms_board = new();

	int unsigned idle_pct  = 0;   // chance in a hundred the sender skips a cycle
	int unsigned stall_pct = 0;   // chance in a hundred the receiver stalls
	int unsigned hold_seq  = 0;   // bump to start one long hold-off
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned cycle_count = 0;

	horizontal_non_max_suppression_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Result side: random stalls, plus a long hold-off on request.
	always @(posedge clk) begin
		if (hold_seen != hold_seq) begin
			hold_seen <= hold_seq;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready  <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Check every accepted result request against the oldest expectation.
	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			nms_board.check_result(m_tdata, m_tlast, m_tuser);

	function automatic pixel_t gradient_sample();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		case (pick)
			8:       return 16'sh7FFF;
			9:       return 16'sh8000;
			4, 5, 6, 7:
				// narrow spread around zero makes ties frequent
				return pixel_t'(int'($urandom_range(0, 6)) - 3);
			default: return pixel_t'($urandom);
		endcase
	endfunction

	// Offer one pixel, with random gaps ahead of it; hold until accepted.
	task automatic send_pixel(input pixel_t v);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		nms_board.note_pixel(v);
	endtask

	// Drop the input and wait until every expected result is out.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (nms_board.expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Leaves cfg_valid high; the caller drops it after the last write.
	task automatic cfg_write(input cfg_idx_t idx, input logic [12:0] word);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= word;
		do @(posedge clk); while (!cfg_ready);
		nms_board.set_reg(idx, word);
	endtask

	task automatic configure(input logic [12:0] half_word, input logic [12:0] width_word);
		settle();
		cfg_write(REG_HALF_LENGTH, half_word);
		cfg_write(REG_ROW_WIDTH, width_word);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_idling(input int unsigned mode);
		case (mode)
			1:       begin idle_pct = 66; stall_pct = 0;  end
			2:       begin idle_pct = 0;  stall_pct = 66; end
			3:       begin idle_pct = 28; stall_pct = 28; end
			default: begin idle_pct = 0;  stall_pct = 0;  end
		endcase
	endtask

	initial begin
		int unsigned l;
		int unsigned w;
		int unsigned pick;
		logic [12:0] half_word;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes, ties and a full tie row with a five-wide window.
		configure(13'd2, 13'd7);
		send_pixel(16'sh7FFF);
		send_pixel(16'sh8000);
		send_pixel(16'sh0000);
		send_pixel(16'shFFFF);
		repeat (3) send_pixel(16'sd5);
		repeat (7) send_pixel(16'sh8000);
		// Zero half length: every pixel passes.
		configure(13'd0, 13'd3);
		send_pixel(16'sd3);
		send_pixel(-16'sd3);
		send_pixel(16'sd1);
		// One-pixel rows, then a zero width that clamps to one.
		configure(13'd15, 13'd1);
		send_pixel(16'sd4);
		send_pixel(-16'sd4);
		configure(13'd15, 13'd0);
		send_pixel(16'sd6);
		// Row narrower than the window: row-end rule wins, windows clip.
		configure(13'd15, 13'd5);
		send_pixel(16'sd1);
		send_pixel(16'sd9);
		send_pixel(16'sd2);
		send_pixel(16'sd9);
		send_pixel(16'sd3);

		// Widest window with the width clamped to the maximum; the row stays open.
		configure(13'd15, 13'h1FFF);
		for (int i = 0; i < 40; i++)
			send_pixel(gradient_sample());

		// Random settings; a new width below the current column ends that row.
		for (int p = 0; p < 12; p++) begin
			case (p % 5)
				0:       l = 0;
				1:       l = 15;
				default: l = $urandom_range(0, 15);
			endcase
			pick = $urandom_range(0, 9);
			if (pick <= 5)
				w = 2 * l + 1 + $urandom_range(0, 30);
			else if (pick <= 7)
				w = $urandom_range(1, 2 * l + 1);
			else if (pick == 8)
				w = (p % 2) ? 0 : 13'h1FFF;
			else
				w = $urandom_range(1, 8191);
			// junk above bit 3 must be ignored
			half_word = {9'($urandom_range(0, 511)), 4'(l)};
			configure(half_word, 13'(w));
			set_idling(p % 4);
			if (p == 4)
				hold_seq = hold_seq + 1;
			for (int i = 0; i < 32; i++)
				send_pixel(gradient_sample());
		end

		set_idling(0);
		settle();
		repeat (20) @(posedge clk);
		if (nms_board.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
